### rtl/dtlr_pkg.sv
package dtlr_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 32;
  localparam int DEPTH_BITS    = 16;

  localparam int DIV_BITS = 16;
  localparam int LEN_BITS = 6;

  localparam logic [7:0] EPSILON_RESET     = 8'd1;
  localparam logic       REG_DEPTH_EPSILON = 1'b0;

  typedef struct packed {
    logic        [5:0]  x_start;
    logic        [4:0]  y_start;
    logic signed [15:0] depth_start;
    logic        [5:0]  x_end;
    logic        [4:0]  y_end;
    logic signed [15:0] depth_end;
    logic        [7:0]  line_color;
  } line_req_t;

  typedef struct packed {
    logic        [5:0]  pixel_x;
    logic        [4:0]  pixel_y;
    logic signed [15:0] pixel_depth;
    logic        [7:0]  pixel_color;
    logic               visible;
    logic               last;
  } pixel_t;

endpackage

### rtl/dtlr_div.sv
module dtlr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dtlr_pkg::DIV_BITS-1:0]     dividend,
  input  logic [dtlr_pkg::LEN_BITS-1:0]     divisor,
  output logic                              done,
  output logic [dtlr_pkg::DIV_BITS-1:0]     quot,
  output logic [dtlr_pkg::LEN_BITS-1:0]     rem
);

  localparam int CW = $clog2(dtlr_pkg::DIV_BITS + 1);

  logic [CW-1:0]                   count;
  logic                            running;
  logic [dtlr_pkg::LEN_BITS-1:0]   dvs;
  logic [dtlr_pkg::LEN_BITS:0]     trial;
  logic                            fits;

  assign trial = {rem, quot[dtlr_pkg::DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CW'(dtlr_pkg::DIV_BITS);
        quot    <= dividend;
        rem     <= '0;
        dvs     <= divisor;
      end else if (running) begin
        quot <= {quot[dtlr_pkg::DIV_BITS-2:0], fits};
        rem  <= fits ? dtlr_pkg::LEN_BITS'(trial - {1'b0, dvs})
                     : trial[dtlr_pkg::LEN_BITS-1:0];
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/dtlr_store.sv
module dtlr_store #(
  parameter int ENTRIES = dtlr_pkg::SCREEN_WIDTH * dtlr_pkg::SCREEN_HEIGHT,
  parameter int DW      = dtlr_pkg::DEPTH_BITS,
  parameter int AW      = $clog2(ENTRIES),
  parameter logic [DW-1:0] FAR = '0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          busy
);

  logic [DW-1:0] mem [ENTRIES];
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == AW'(ENTRIES - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= FAR;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/depth_tested_line_raster_unit.sv
// channel  | dir | payload               | handshake
// line     | in  | dtlr_pkg::line_req_t  | line_valid / line_ready
// pixel    | out | dtlr_pkg::pixel_t     | pixel_valid / pixel_ready
// apb      | in  | depth_epsilon at 0x0  | psel / penable / pready
//
// A line request is loaded, then the depth slope is divided bit-serially, then stepping starts,
// one pixel per cycle while the pixel output is not stalled, through the depth store port
// (read, test, write back), and the test stage drains before the next request is taken.
// A single-pixel line skips the divide. After reset the store is swept to far, all
// SCREEN_WIDTH*SCREEN_HEIGHT entries, with line_ready low.
// A stalled pixel output holds the pipeline; the stalled pixel is re-read.
module depth_tested_line_raster_unit #(
  parameter int SCREEN_WIDTH  = dtlr_pkg::SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = dtlr_pkg::SCREEN_HEIGHT,
  parameter int DEPTH_BITS    = dtlr_pkg::DEPTH_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                line_valid,
  output logic                line_ready,
  input  dtlr_pkg::line_req_t line,
  output logic                pixel_valid,
  input  logic                pixel_ready,
  output dtlr_pkg::pixel_t    pixel,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int ENTRIES = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW      = $clog2(ENTRIES);
  localparam int SW      = DEPTH_BITS > 16 ? DEPTH_BITS : 16;
  localparam logic [SW-1:0] FAR = SW'((64'd1 << (DEPTH_BITS - 1)) - 64'd1);
  localparam int LB = dtlr_pkg::LEN_BITS;
  localparam int QB = dtlr_pkg::DIV_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_RUN} state_t;

  state_t state;
  logic [7:0] depth_epsilon;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == dtlr_pkg::REG_DEPTH_EPSILON) ? {24'd0, depth_epsilon} : 32'd0;

  // line setup
  logic signed [6:0]  sdx, sdy;
  logic [5:0]         adx, ady;
  logic signed [16:0] ddiff;
  logic [QB-1:0]      amag;
  logic               xmaj_in, rev_in, zero_in, up_in;
  logic [LB-1:0]      len_in;

  assign sdx = $signed({1'b0, line.x_end}) - $signed({1'b0, line.x_start});
  assign sdy = $signed({2'b0, line.y_end}) - $signed({2'b0, line.y_start});
  assign adx = sdx[6] ? 6'(-sdx) : sdx[5:0];
  assign ady = sdy[6] ? 6'(-sdy) : sdy[5:0];
  assign ddiff = $signed({line.depth_end[15], line.depth_end})
               - $signed({line.depth_start[15], line.depth_start});
  assign amag = ddiff[16] ? QB'(-ddiff) : ddiff[15:0];
  assign xmaj_in = ady <= adx;
  assign rev_in  = xmaj_in ? sdx[6] : sdy[6];
  assign zero_in = (adx == 6'd0) && (ady == 6'd0);
  assign up_in   = (sdx[6] == sdy[6]) && (sdx != 7'sd0) && (sdy != 7'sd0);
  assign len_in  = xmaj_in ? adx : ady;

  logic accept;
  logic store_busy;
  assign line_ready = (state == ST_IDLE) && !store_busy;
  assign accept     = line_valid && line_ready;

  // divider
  logic          div_done;
  logic [QB-1:0] qa;
  logic [LB-1:0] ra;

  dtlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && !zero_in),
    .dividend (amag),
    .divisor  (len_in),
    .done     (div_done),
    .quot     (qa),
    .rem      (ra)
  );

  // line registers
  logic               xmaj, rev, up, dneg;
  logic [5:0]         ldx, ldy;
  logic [LB-1:0]      len;
  logic [QB-1:0]      lmag;
  logic signed [15:0] d1;
  logic [7:0]         color;

  // stepper
  logic [5:0]         cx;
  logic [4:0]         cy;
  logic signed [8:0]  err;
  logic [QB-1:0]      q;
  logic [LB-1:0]      r;
  logic [6:0]         remain;

  logic [5:0]         cx_next;
  logic [4:0]         cy_next;
  logic signed [8:0]  err_next;
  logic [QB-1:0]      q_next;
  logic [LB-1:0]      r_next;
  logic [LB:0]        rsum;
  logic signed [LB+1:0] rdif;
  logic signed [17:0] cdepth;
  logic [AW-1:0]      caddr;
  logic               con;

  always_comb begin
    cx_next  = cx;
    cy_next  = cy;
    err_next = err;
    if (xmaj) begin
      cx_next = cx + 6'd1;
      if (err < 0) begin
        err_next = err + $signed({2'b0, ldy, 1'b0});
      end else begin
        cy_next  = up ? cy + 5'd1 : cy - 5'd1;
        err_next = err + $signed({2'b0, ldy, 1'b0}) - $signed({2'b0, ldx, 1'b0});
      end
    end else begin
      cy_next = cy + 5'd1;
      if (err <= 0) begin
        err_next = err + $signed({2'b0, ldx, 1'b0});
      end else begin
        cx_next  = up ? cx + 6'd1 : cx - 6'd1;
        err_next = err + $signed({2'b0, ldx, 1'b0}) - $signed({2'b0, ldy, 1'b0});
      end
    end
    rsum = {1'b0, r} + {1'b0, ra};
    rdif = $signed({2'b0, r}) - $signed({2'b0, ra});
    if (!rev) begin
      if (rsum >= {1'b0, len}) begin
        r_next = LB'(rsum - {1'b0, len});
        q_next = q + qa + QB'(1);
      end else begin
        r_next = rsum[LB-1:0];
        q_next = q + qa;
      end
    end else begin
      if (rdif < 0) begin
        r_next = LB'(rdif + $signed({2'b0, len}));
        q_next = q - qa - QB'(1);
      end else begin
        r_next = rdif[LB-1:0];
        q_next = q - qa;
      end
    end
  end

  assign cdepth = $signed({{2{d1[15]}}, d1})
                + (dneg ? -$signed({2'b0, q}) : $signed({2'b0, q}));
  assign caddr = AW'(32'(cy) * SCREEN_WIDTH + 32'(cx));
  assign con   = ({1'b0, cx} < 7'(SCREEN_WIDTH)) && ({2'b0, cy} < 7'(SCREEN_HEIGHT));

  // test stage
  logic               stage_valid, stage_on, stage_last;
  logic [5:0]         stage_x;
  logic [4:0]         stage_y;
  logic signed [15:0] stage_depth;
  logic [AW-1:0]      stage_addr;
  logic               stage_go, step;

  assign stage_go = stage_valid && (!pixel_valid || pixel_ready);
  assign step     = (state == ST_RUN) && (remain != 7'd0) && (!stage_valid || stage_go);

  // depth store
  logic [SW-1:0]        stored;
  logic signed [SW:0]   margin_d;
  logic signed [SW:0]   gap;
  logic                 vis;
  logic [7:0]           margin;

  assign margin = (depth_epsilon == 8'd0) ? 8'd1 : depth_epsilon;
  assign gap = $signed({stored[SW-1], stored})
             - $signed({{(SW-15){stage_depth[15]}}, stage_depth});
  assign margin_d = $signed({{(SW-7){1'b0}}, margin});
  assign vis = stage_on && !stage_depth[15] && (gap >= margin_d);

  dtlr_store #(
    .ENTRIES (ENTRIES),
    .DW      (SW),
    .AW      (AW),
    .FAR     (FAR)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (step ? caddr : stage_addr),
    .rd_data (stored),
    .wr_en   (stage_go && vis),
    .wr_addr (stage_addr),
    .wr_data ({{(SW-15){stage_depth[15]}}, stage_depth[14:0]}),
    .busy    (store_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      depth_epsilon <= dtlr_pkg::EPSILON_RESET;
      stage_valid   <= 1'b0;
      pixel_valid   <= 1'b0;
      remain        <= '0;
    end else begin
      if (psel && penable && pwrite && paddr[2] == dtlr_pkg::REG_DEPTH_EPSILON) begin
        depth_epsilon <= pwdata[7:0];
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            xmaj   <= xmaj_in;
            rev    <= rev_in;
            up     <= up_in;
            dneg   <= ddiff[16];
            ldx    <= adx;
            ldy    <= ady;
            len    <= len_in;
            lmag   <= amag;
            d1     <= line.depth_start;
            color  <= line.line_color;
            cx     <= rev_in ? line.x_end : line.x_start;
            cy     <= rev_in ? line.y_end : line.y_start;
            err    <= xmaj_in ? 9'($signed({3'b0, ady, 1'b0}) - $signed({3'b0, adx}))
                              : 9'($signed({3'b0, adx, 1'b0}) - $signed({3'b0, ady}));
            remain <= 7'({1'b0, len_in}) + 7'd1;
            q      <= '0;
            r      <= '0;
            state  <= zero_in ? ST_RUN : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            q     <= rev ? lmag : '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (remain == 7'd0 && (!stage_valid || stage_go)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (step) begin
        stage_valid <= 1'b1;
        stage_x     <= cx;
        stage_y     <= cy;
        stage_depth <= cdepth[15:0];
        stage_addr  <= caddr;
        stage_on    <= con;
        stage_last  <= remain == 7'd1;
        remain      <= remain - 7'd1;
        cx          <= cx_next;
        cy          <= cy_next;
        err         <= err_next;
        q           <= q_next;
        r           <= r_next;
      end else if (stage_go) begin
        stage_valid <= 1'b0;
      end

      if (stage_go) begin
        pixel_valid       <= 1'b1;
        pixel.pixel_x     <= stage_x;
        pixel.pixel_y     <= stage_y;
        pixel.pixel_depth <= stage_depth;
        pixel.pixel_color <= color;
        pixel.visible     <= vis;
        pixel.last        <= stage_last;
      end else if (pixel_ready) begin
        pixel_valid <= 1'b0;
      end
    end
  end

endmodule
